/* hdl/pmon_pkg.sv */
// Shared types and constants for the pump safety fault monitor.
// Used by every module under hdl; no dependencies of its own.
package pmon_pkg;

	// Field widths
	localparam int unsigned TimeW  = 64;
	localparam int unsigned PresW  = 16;
	localparam int unsigned RpmW   = 20;
	localparam int unsigned DivW   = 21;
	localparam int unsigned CountW = 16;
	localparam int unsigned StateW = 4;
	localparam int unsigned LimW   = 21;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 20;
	localparam int unsigned InDataW = 192;
	localparam int unsigned OutDataW = 152;
	localparam int unsigned NumFaults = 4;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_PRESSURE_LIMIT = 3'd0,
		CFG_DIV_THRESHOLD  = 3'd1,
		CFG_DIV_TICKS      = 3'd2,
		CFG_LOOP_PERIOD    = 3'd3,
		CFG_JITTER         = 3'd4
	} cfg_idx_t;

	// Fault codes, also the bit position in the pending mask
	typedef enum logic [1:0] {
		FAULT_OVERPRESSURE = 2'd0,
		FAULT_AIR          = 2'd1,
		FAULT_MOTOR_STALL  = 2'd2,
		FAULT_LOOP_TIMING  = 2'd3
	} fault_t;

	// Register reset values
	localparam logic [15:0] RstPressureLimit = 16'hFFFF;
	localparam logic [19:0] RstDivThreshold  = 20'hFFFFF;
	localparam logic [15:0] RstDivTicks      = 16'd5;
	localparam logic [19:0] RstLoopPeriod    = 20'd1000;
	localparam logic [19:0] RstJitter        = 20'd500;

	// Current configuration, with the loop timing limit precomputed
	typedef struct packed {
		logic [15:0]     pressure_limit;
		logic [19:0]     divergence_threshold;
		logic [15:0]     divergence_ticks;
		logic [LimW-1:0] loop_limit;
	} cfg_t;

	// Fault set found on one tick, handed to the event serializer
	typedef struct packed {
		logic [NumFaults-1:0] mask;
		logic [PresW-1:0]     pressure;
		logic [PresW-1:0]     pressure_limit;
		logic [DivW-1:0]      divergence;
		logic [19:0]          divergence_threshold;
		logic [TimeW-1:0]     elapsed;
		logic [LimW-1:0]      loop_limit;
		logic [TimeW-1:0]     timestamp;
	} ev_t;

endpackage

/* hdl/pmon_cfg.sv */
// Configuration register file of the fault monitor.
// Depends on pmon_pkg for register indexes and the cfg_t bundle.
module pmon_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pmon_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [pmon_pkg::CfgDataW-1:0]  cfg_data,
	output pmon_pkg::cfg_t                 cfg
);
	import pmon_pkg::*;

	logic [15:0] pressure_limit_q;
	logic [19:0] div_threshold_q;
	logic [15:0] div_ticks_q;
	logic [19:0] loop_period_q;
	logic [19:0] jitter_q;

	assign cfg_ready = 1'b1;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressure_limit_q <= RstPressureLimit;
			div_threshold_q  <= RstDivThreshold;
			div_ticks_q      <= RstDivTicks;
			loop_period_q    <= RstLoopPeriod;
			jitter_q         <= RstJitter;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PRESSURE_LIMIT: pressure_limit_q <= cfg_data[15:0];
				CFG_DIV_THRESHOLD:  div_threshold_q  <= cfg_data;
				CFG_DIV_TICKS:      div_ticks_q      <= cfg_data[15:0];
				CFG_LOOP_PERIOD:    loop_period_q    <= cfg_data;
				CFG_JITTER:         jitter_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	// Bundle out, loop limit is period plus jitter
	always_comb begin
		cfg.pressure_limit       = pressure_limit_q;
		cfg.divergence_threshold = div_threshold_q;
		cfg.divergence_ticks     = div_ticks_q;
		cfg.loop_limit           = {1'b0, loop_period_q} + {1'b0, jitter_q};
	end

endmodule

/* hdl/pmon_check.sv */
// Input register and fault checks of the monitor, with the tick-to-tick state.
// Depends on pmon_pkg; feeds an ev_t bundle to pmon_emit.
module pmon_check (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [pmon_pkg::InDataW-1:0]   s_tdata,
	input  pmon_pkg::cfg_t                 cfg,
	input  logic                           buf_free,
	output logic                           ev_load,
	output pmon_pkg::ev_t                  ev
);
	import pmon_pkg::*;

	// Input field slices
	logic [TimeW-1:0]  in_now;
	logic [TimeW-1:0]  in_last;
	logic [RpmW-1:0]   in_cmd;
	logic [RpmW-1:0]   in_act;
	logic [TimeW:0]    in_diff;
	logic [DivW-1:0]   in_d;
	logic [DivW-1:0]   in_abs;

	// Stage 1 registers
	logic              valid_s1;
	logic [TimeW-1:0]  now_s1;
	logic [TimeW-1:0]  elapsed_s1;
	logic              tick_ok_s1;
	logic [PresW-1:0]  pres_s1;
	logic              air_s1;
	logic [DivW-1:0]   div_s1;
	logic              inj_s1;
	logic [StateW-1:0] st_s1;
	logic              rest_s1;

	// Tick-to-tick state
	logic [CountW-1:0] div_count_q;
	logic              latched_q;
	logic [StateW-1:0] seen_state_q;
	logic              seen_valid_q;

	// Check logic
	logic              adv;
	logic              clr;
	logic [CountW-1:0] count_base;
	logic              latch_base;
	logic              div_over;
	logic [CountW-1:0] count_next;
	logic [NumFaults-1:0] faults;

	assign in_now  = s_tdata[63:0];
	assign in_last = s_tdata[127:64];
	assign in_cmd  = s_tdata[164:145];
	assign in_act  = s_tdata[184:165];

	// Elapsed time with borrow, and rpm divergence, ahead of the register
	assign in_diff = {1'b0, in_now} - {1'b0, in_last};
	assign in_d    = {in_cmd[RpmW-1], in_cmd} - {in_act[RpmW-1], in_act};
	assign in_abs  = in_d[DivW-1] ? (~in_d + {{(DivW-1){1'b0}}, 1'b1}) : in_d;

	assign adv      = valid_s1 && buf_free;
	assign s_tready = !valid_s1 || buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Payload of stage 1
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			now_s1     <= in_now;
			elapsed_s1 <= in_diff[TimeW-1:0];
			tick_ok_s1 <= (in_last != '0) && !in_diff[TimeW];
			pres_s1    <= s_tdata[143:128];
			air_s1     <= s_tdata[144];
			div_s1     <= in_abs;
			inj_s1     <= s_tdata[185];
			st_s1      <= s_tdata[189:186];
			rest_s1    <= s_tdata[190];
		end
	end

	// Rest-state clear, then the four checks
	always_comb begin
		clr        = (!seen_valid_q || st_s1 != seen_state_q) && rest_s1;
		count_base = clr ? '0 : div_count_q;
		latch_base = clr ? 1'b0 : latched_q;
		div_over   = div_s1 > {1'b0, cfg.divergence_threshold};
		if (!div_over) begin
			count_next = '0;
		end else if (count_base == '1) begin
			count_next = count_base;
		end else begin
			count_next = count_base + {{(CountW-1){1'b0}}, 1'b1};
		end
		faults[FAULT_OVERPRESSURE] = pres_s1 > cfg.pressure_limit;
		faults[FAULT_AIR]          = air_s1;
		faults[FAULT_MOTOR_STALL]  = div_over && (count_next >= cfg.divergence_ticks);
		faults[FAULT_LOOP_TIMING]  = inj_s1 && tick_ok_s1 &&
			(elapsed_s1 > {{(TimeW-LimW){1'b0}}, cfg.loop_limit});
	end

	// State update once the tick leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_count_q  <= '0;
			latched_q    <= 1'b0;
			seen_state_q <= '0;
			seen_valid_q <= 1'b0;
		end else if (adv) begin
			div_count_q  <= count_next;
			latched_q    <= latch_base || (faults != '0);
			seen_state_q <= st_s1;
			seen_valid_q <= 1'b1;
		end
	end

	assign ev_load = adv && (faults != '0) && !latch_base;

	always_comb begin
		ev.mask                 = faults;
		ev.pressure             = pres_s1;
		ev.pressure_limit       = cfg.pressure_limit;
		ev.divergence           = div_s1;
		ev.divergence_threshold = cfg.divergence_threshold;
		ev.elapsed              = elapsed_s1;
		ev.loop_limit           = cfg.loop_limit;
		ev.timestamp            = now_s1;
	end

endmodule

/* hdl/pmon_emit.sv */
// Event buffer and serializer: sends the faults of one tick in check order.
// Depends on pmon_pkg; loaded from pmon_check.
module pmon_emit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           ev_load,
	input  pmon_pkg::ev_t                  ev,
	output logic                           buf_free,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [pmon_pkg::OutDataW-1:0]  m_tdata,
	output logic [1:0]                     m_tuser,
	output logic                           m_tlast
);
	import pmon_pkg::*;

	logic [NumFaults-1:0] mask_q;
	ev_t                  ev_q;
	logic [NumFaults-1:0] cur;
	fault_t               cur_type;
	logic [TimeW-1:0]     measured;
	logic [LimW-1:0]      limit;
	logic                 xfer;

	// Pick the lowest pending fault
	always_comb begin
		priority if (mask_q[FAULT_OVERPRESSURE]) begin
			cur_type = FAULT_OVERPRESSURE;
		end else if (mask_q[FAULT_AIR]) begin
			cur_type = FAULT_AIR;
		end else if (mask_q[FAULT_MOTOR_STALL]) begin
			cur_type = FAULT_MOTOR_STALL;
		end else begin
			cur_type = FAULT_LOOP_TIMING;
		end
		cur = '0;
		cur[cur_type] = 1'b1;
	end

	// Values for the selected fault
	always_comb begin
		unique case (cur_type)
			FAULT_OVERPRESSURE: begin
				measured = {{(TimeW-PresW){1'b0}}, ev_q.pressure};
				limit    = {{(LimW-PresW){1'b0}}, ev_q.pressure_limit};
			end
			FAULT_AIR: begin
				measured = {{(TimeW-1){1'b0}}, 1'b1};
				limit    = '0;
			end
			FAULT_MOTOR_STALL: begin
				measured = {{(TimeW-DivW){1'b0}}, ev_q.divergence};
				limit    = {1'b0, ev_q.divergence_threshold};
			end
			default: begin
				measured = ev_q.elapsed;
				limit    = ev_q.loop_limit;
			end
		endcase
	end

	assign m_tvalid = mask_q != '0;
	assign m_tlast  = (mask_q & ~cur) == '0;
	assign m_tuser  = cur_type;
	assign m_tdata  = {3'b000, ev_q.timestamp, limit, measured};
	assign xfer     = m_tvalid && m_tready;
	assign buf_free = !m_tvalid || (xfer && m_tlast);

	// Pending mask: load a new tick or retire one fault per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (ev_load) begin
			mask_q <= ev.mask;
		end else if (xfer) begin
			mask_q <= mask_q & ~cur;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_load) begin
			ev_q <= ev;
		end
	end

	// A new tick never overwrites faults still waiting
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ev_load |-> buf_free)
		else $error("event buffer loaded while busy");

	// Last flag marks exactly one pending fault
	a_last_single: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> $onehot(mask_q))
		else $error("tlast with several faults pending");

	// Each transfer without a load retires exactly one fault
	a_retire_one: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && !ev_load) |=> ($countones(mask_q) + 1 == $countones($past(mask_q))))
		else $error("transfer did not retire one fault");

	// A loaded tick always carries at least one fault
	a_load_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ev_load |=> m_tvalid)
		else $error("empty fault set loaded");

endmodule

/* hdl/pump_safety_fault_monitor.sv */
// Pump safety fault monitor, top level.
// Channels: s_* takes one monitor tick per transfer; m_* returns fault events,
// fault_type in tuser, tlast on the final event of a tick. cfg_* writes the
// five threshold registers (index 0..4, other indexes ignored); it is always
// ready and should only be written while no tick is in flight.
// Path: a tick accepted on s_* is checked in the input register; its faults
// then load the event buffer, which puts the first event on m_*. A tick that
// finds no fault, or faults while the emergency latch is set, produces no event.
// Throughput: one tick per cycle while the event buffer is free; a tick that
// raises k faults holds the single-entry event buffer for k transfers, so the
// next tick waits in the input register and s_tready drops meanwhile.
// A stalled receiver holds the current event steady and backs up into s_*.
// Reset clears the pipeline, the pending events, the divergence counter, the
// latch and the seen-state record, and restores register defaults.
// Depends on pmon_pkg, pmon_cfg, pmon_check, pmon_emit.
module pump_safety_fault_monitor (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// now_us[63:0], last_loop_tick_us[127:64], pressure[143:128],
	// air_detected[144], commanded_rpm[164:145], actual_rpm[184:165],
	// injecting[185], state_code[189:186], state_is_rest[190], zero[191]
	input  logic [pmon_pkg::InDataW-1:0]   s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// measured_value[63:0], limit_value[84:64], timestamp_us[148:85],
	// zero[151:149]
	output logic [pmon_pkg::OutDataW-1:0]  m_tdata,
	// fault_type[1:0]
	output logic [1:0]                     m_tuser,
	output logic                           m_tlast,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pmon_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [pmon_pkg::CfgDataW-1:0]  cfg_data
);
	import pmon_pkg::*;

	cfg_t cfg;
	ev_t  ev;
	logic ev_load;
	logic buf_free;

	pmon_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pmon_check u_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.cfg      (cfg),
		.buf_free (buf_free),
		.ev_load  (ev_load),
		.ev       (ev)
	);

	pmon_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_load  (ev_load),
		.ev       (ev),
		.buf_free (buf_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
